@@ hw/rtl/tod_pkg.sv @@
// Shared types, codes and limits for the time-of-day clock unit.
package tod_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_TICK = 3'd0;
    localparam logic [2:0] REQ_UP   = 3'd1;
    localparam logic [2:0] REQ_DOWN = 3'd2;
    localparam logic [2:0] REQ_NEXT = 3'd3;

    // Set mode codes
    localparam logic [1:0] SET_NONE    = 2'd0;
    localparam logic [1:0] SET_HOURS   = 2'd1;
    localparam logic [1:0] SET_MINUTES = 2'd2;
    localparam logic [1:0] SET_SECONDS = 2'd3;

    // Highest legal value of each time field
    localparam logic [4:0] HOUR_TOP = 5'd23;
    localparam logic [5:0] MIN_TOP  = 6'd59;
    localparam logic [5:0] SEC_TOP  = 6'd59;

    typedef struct packed {
        logic [2:0] req_type;
        logic       key_pressed;
        logic       shift_held;
    } tod_req_t;

    typedef struct packed {
        logic [4:0] hours_now;
        logic [5:0] minutes_now;
        logic [5:0] seconds_now;
        logic [1:0] set_field;
        logic       passed_on;
    } tod_res_t;

    // Step a field up, wrapping after its top value
    function automatic logic [5:0] step_up(input logic [5:0] v, input logic [5:0] top);
        logic [5:0] r;
        r = (v >= top) ? 6'd0 : v + 6'd1;
        return r;
    endfunction

    // Step a field down, wrapping from zero to its top value
    function automatic logic [5:0] step_down(input logic [5:0] v, input logic [5:0] top);
        logic [5:0] r;
        r = (v == 6'd0 || v > top) ? top : v - 6'd1;
        return r;
    endfunction

endpackage

@@ hw/rtl/tod_in_stage.sv @@
// Input register stage: captures one request transaction ahead of the core.
module tod_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tod_pkg::tod_req_t s_data,
    output logic              req_valid,
    input  logic              req_take,
    output tod_pkg::tod_req_t req_data
);

    logic              valid_reg;
    logic              valid_next;
    tod_pkg::tod_req_t data_reg;

    // Accept when empty or when the held request moves on this cycle
    assign s_ready = !valid_reg || req_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (req_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on every accepted transaction
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign req_valid = valid_reg;
    assign req_data  = data_reg;

endmodule

@@ hw/rtl/tod_core.sv @@
// Clock state, next-time logic and result register.
module tod_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_take,
    input  tod_pkg::tod_req_t req_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tod_pkg::tod_res_t m_data
);

    logic [4:0]        hour_reg;
    logic [4:0]        hour_next;
    logic [5:0]        min_reg;
    logic [5:0]        min_next;
    logic [5:0]        sec_reg;
    logic [5:0]        sec_next;
    logic [1:0]        mode_reg;
    logic [1:0]        mode_next;
    logic              passed;
    logic              sec_wrap;
    logic              min_wrap;
    logic              out_valid_reg;
    tod_pkg::tod_res_t out_data_reg;

    // Move a request into the result register when that register is empty or being drained
    assign req_take = req_valid && (!out_valid_reg || m_ready);

    assign sec_wrap = (sec_reg >= tod_pkg::SEC_TOP);
    assign min_wrap = (min_reg >= tod_pkg::MIN_TOP);

    // Compute the state after this request
    always_comb begin
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        mode_next = mode_reg;
        passed    = 1'b0;
        unique case (req_data.req_type)
            tod_pkg::REQ_TICK: begin
                sec_next = sec_wrap ? 6'd0 : sec_reg + 6'd1;
                if (sec_wrap) begin
                    min_next = min_wrap ? 6'd0 : min_reg + 6'd1;
                    if (min_wrap) begin
                        hour_next = (hour_reg >= tod_pkg::HOUR_TOP) ? 5'd0 : hour_reg + 5'd1;
                    end
                end
            end
            tod_pkg::REQ_UP: begin
                if (req_data.key_pressed) begin
                    case (mode_reg)
                        tod_pkg::SET_HOURS: begin
                            hour_next = 5'(tod_pkg::step_up({1'b0, hour_reg},
                                                            {1'b0, tod_pkg::HOUR_TOP}));
                        end
                        tod_pkg::SET_MINUTES: begin
                            min_next = tod_pkg::step_up(min_reg, tod_pkg::MIN_TOP);
                        end
                        tod_pkg::SET_SECONDS: begin
                            sec_next = tod_pkg::step_up(sec_reg, tod_pkg::SEC_TOP);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tod_pkg::REQ_DOWN: begin
                if (req_data.key_pressed) begin
                    case (mode_reg)
                        tod_pkg::SET_HOURS: begin
                            hour_next = 5'(tod_pkg::step_down({1'b0, hour_reg},
                                                              {1'b0, tod_pkg::HOUR_TOP}));
                        end
                        tod_pkg::SET_MINUTES: begin
                            min_next = tod_pkg::step_down(min_reg, tod_pkg::MIN_TOP);
                        end
                        tod_pkg::SET_SECONDS: begin
                            sec_next = tod_pkg::step_down(sec_reg, tod_pkg::SEC_TOP);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tod_pkg::REQ_NEXT: begin
                if (req_data.key_pressed) begin
                    mode_next = req_data.shift_held ? mode_reg - 2'd1 : mode_reg + 2'd1;
                end
            end
            default: begin
                passed = 1'b1;
            end
        endcase
    end

    // Commit state on each request taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg <= 5'd0;
            min_reg  <= 6'd0;
            sec_reg  <= 6'd0;
            mode_reg <= tod_pkg::SET_NONE;
        end else if (req_take) begin
            hour_reg <= hour_next;
            min_reg  <= min_next;
            sec_reg  <= sec_next;
            mode_reg <= mode_next;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (req_take) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take) begin
            out_data_reg.hours_now   <= hour_next;
            out_data_reg.minutes_now <= min_next;
            out_data_reg.seconds_now <= sec_next;
            out_data_reg.set_field   <= mode_next;
            out_data_reg.passed_on   <= passed;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ hw/rtl/settable_time_of_day_clock_unit.sv @@
// Top level of the settable 24-hour time-of-day clock unit.
// A request accepted on s_valid and s_ready waits in the input register, then goes
// through one pass of next-time logic into the result register that drives m_valid.
// Throughput: one request per cycle while m_ready stays high; the input register
// and the result register let a new request in while a result waits.
// Reset: aresetn low clears the time to 00:00:00, the set mode to none and both stages.
module settable_time_of_day_clock_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tod_pkg::tod_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tod_pkg::tod_res_t m_data
);

    logic              req_valid;
    logic              req_take;
    tod_pkg::tod_req_t req_data;

    tod_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req_data  (req_data)
    );

    tod_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req_data  (req_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ hw/rtl/tod_checker.sv @@
// Port-level checks for the time-of-day clock unit, bound to the top level.
module tod_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input tod_pkg::tod_req_t s_data,
    input logic              m_valid,
    input logic              m_ready,
    input tod_pkg::tod_res_t m_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Time fields stay in range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hours_now <= tod_pkg::HOUR_TOP) &&
                    (m_data.minutes_now <= tod_pkg::MIN_TOP) &&
                    (m_data.seconds_now <= tod_pkg::SEC_TOP))
        else $error("time field out of range");

    // Reset empties the unit and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("unit not empty after reset");

    // A tick into an empty output, drained on the next cycle, never reports a passed-on key
    a_tick_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type == tod_pkg::REQ_TICK) && !m_valid
        ##1 m_ready |=> m_valid && !m_data.passed_on)
        else $error("tick reported as passed-on key");

endmodule

bind settable_time_of_day_clock_unit tod_checker u_tod_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for the settable time-of-day clock unit.
`timescale 1ns / 1ps

module tb_top;

    // Request codes with no constant of their own in the package
    localparam logic [2:0] REQ_OTHER       = 3'd4;
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_MID   = 3'd6;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS  = 900;
    localparam int TAIL_ITEMS    = 150;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;

    // Time-of-day predictor and store of pending results
    class tod_scoreboard;
        tod_pkg::tod_res_t expected_q[$];
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
        logic [1:0] field_sel;
        int         mismatches;
        int         checked;
        int         ticks;
        int         minute_carries;
        int         hour_carries;
        int         set_presses;
        int         passed_keys;

        function new();
            hh             = '0;
            mm             = '0;
            ss             = '0;
            field_sel      = tod_pkg::SET_NONE;
            mismatches     = 0;
            checked        = 0;
            ticks          = 0;
            minute_carries = 0;
            hour_carries   = 0;
            set_presses    = 0;
            passed_keys    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Step the selected field one unit, wrapping at its limits
        function void adjust_field(bit upward);
            case (field_sel)
                tod_pkg::SET_HOURS: begin
                    if (upward) hh = (hh == tod_pkg::HOUR_TOP) ? 5'd0 : hh + 5'd1;
                    else        hh = (hh == 5'd0) ? tod_pkg::HOUR_TOP : hh - 5'd1;
                end
                tod_pkg::SET_MINUTES: begin
                    if (upward) mm = (mm == tod_pkg::MIN_TOP) ? 6'd0 : mm + 6'd1;
                    else        mm = (mm == 6'd0) ? tod_pkg::MIN_TOP : mm - 6'd1;
                end
                tod_pkg::SET_SECONDS: begin
                    if (upward) ss = (ss == tod_pkg::SEC_TOP) ? 6'd0 : ss + 6'd1;
                    else        ss = (ss == 6'd0) ? tod_pkg::SEC_TOP : ss - 6'd1;
                end
                default: ;
            endcase
        endfunction

        // Apply one accepted request and queue the result it must produce
        function void note_request(tod_pkg::tod_req_t r);
            tod_pkg::tod_res_t want;
            logic              passed;
            passed = 1'b0;
            case (r.req_type)
                tod_pkg::REQ_TICK: begin
                    ticks++;
                    if (ss == tod_pkg::SEC_TOP) begin
                        ss = 6'd0;
                        minute_carries++;
                        if (mm == tod_pkg::MIN_TOP) begin
                            mm = 6'd0;
                            hour_carries++;
                            hh = (hh == tod_pkg::HOUR_TOP) ? 5'd0 : hh + 5'd1;
                        end else begin
                            mm = mm + 6'd1;
                        end
                    end else begin
                        ss = ss + 6'd1;
                    end
                end
                tod_pkg::REQ_UP: begin
                    if (r.key_pressed) begin
                        set_presses++;
                        adjust_field(1'b1);
                    end
                end
                tod_pkg::REQ_DOWN: begin
                    if (r.key_pressed) begin
                        set_presses++;
                        adjust_field(1'b0);
                    end
                end
                tod_pkg::REQ_NEXT: begin
                    if (r.key_pressed) begin
                        set_presses++;
                        field_sel = r.shift_held ? field_sel - 2'd1 : field_sel + 2'd1;
                    end
                end
                default: begin
                    passed = 1'b1;
                    passed_keys++;
                end
            endcase
            want.hours_now   = hh;
            want.minutes_now = mm;
            want.seconds_now = ss;
            want.set_field   = field_sel;
            want.passed_on   = passed;
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        // Compare one result transaction against the oldest expectation
        task check_result(tod_pkg::tod_res_t got);
            tod_pkg::tod_res_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %h arrived with nothing pending", got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.hours_now !== want.hours_now)
                report_mismatch($sformatf("result %0d hours_now: got %0d, expected %0d",
                                          checked, got.hours_now, want.hours_now));
            if (got.minutes_now !== want.minutes_now)
                report_mismatch($sformatf("result %0d minutes_now: got %0d, expected %0d",
                                          checked, got.minutes_now, want.minutes_now));
            if (got.seconds_now !== want.seconds_now)
                report_mismatch($sformatf("result %0d seconds_now: got %0d, expected %0d",
                                          checked, got.seconds_now, want.seconds_now));
            if (got.set_field !== want.set_field)
                report_mismatch($sformatf("result %0d set_field: got %0d, expected %0d",
                                          checked, got.set_field, want.set_field));
            if (got.passed_on !== want.passed_on)
                report_mismatch($sformatf("result %0d passed_on: got %0d, expected %0d",
                                          checked, got.passed_on, want.passed_on));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    tod_pkg::tod_req_t s_data;
    logic              m_valid;
    logic              m_ready;
    tod_pkg::tod_res_t m_data;

    tod_scoreboard board = new();
    int            cycle_count = 0;
    int            sent_count = 0;
    int            holds_done = 0;
    bit            tail_phase = 1'b0;
    bit            sink_hold_request = 1'b0;

    settable_time_of_day_clock_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock, 20 ns period
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // End the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycle_count, board.pending());
            $display("tb_top: errors");
            $finish;
        end
    end

    // Check every accepted result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
    end

    // Drive m_ready: random stall bursts, quiet stretches, one long hold-off
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (sink_hold_request) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                sink_hold_request = 1'b0;
                holds_done++;
            end else if (tail_phase || (cycle_count / 3000) % 3 == 0
                         || $urandom_range(0, 7) != 0) begin
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge aclk);
            end
        end
    end

    // Offer one request transaction and hold it until accepted
    task send_request(tod_pkg::tod_req_t r);
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = r;
        do @(posedge aclk); while (!s_ready);
        board.note_request(r);
        sent_count++;
    endtask

    // Drop valid for a burst of idle cycles, with junk on the payload
    task idle_sender(int cycles);
        @(negedge aclk);
        s_valid = 1'b0;
        s_data  = tod_pkg::tod_req_t'(5'($urandom));
        repeat (cycles - 1) @(negedge aclk);
    endtask

    initial begin
        tod_pkg::tod_req_t directed_reqs[$];
        tod_pkg::tod_req_t next_req;
        int unsigned       pick;
        int                burst_until;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        burst_until = 0;

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: pass-through keys, releases, mode walk, wraps, full carry
        directed_reqs = '{
            {tod_pkg::REQ_TICK, 1'b0, 1'b1},   // tick ignores pressed and shift
            {tod_pkg::REQ_UP,   1'b1, 1'b0},   // up with no field selected
            {REQ_OTHER,         1'b1, 1'b0},
            {REQ_OTHER,         1'b0, 1'b1},   // other key passes on when released too
            {REQ_SPARE_FIRST,   1'b1, 1'b0},   // unused codes act as other keys
            {REQ_SPARE_MID,     1'b0, 1'b0},
            {REQ_SPARE_LAST,    1'b1, 1'b1},
            {tod_pkg::REQ_NEXT, 1'b1, 1'b1},   // backward from none to seconds
            {tod_pkg::REQ_NEXT, 1'b0, 1'b0},   // release changes nothing
            {tod_pkg::REQ_NEXT, 1'b1, 1'b0},   // forward seconds to none
            {tod_pkg::REQ_NEXT, 1'b1, 1'b0},   // hours
            {tod_pkg::REQ_DOWN, 1'b1, 1'b0},   // 0 -> 23
            {tod_pkg::REQ_UP,   1'b0, 1'b0},   // release of up
            {tod_pkg::REQ_UP,   1'b1, 1'b0},   // 23 -> 0
            {tod_pkg::REQ_DOWN, 1'b1, 1'b0},   // back to 23
            {tod_pkg::REQ_NEXT, 1'b1, 1'b0},   // minutes
            {tod_pkg::REQ_DOWN, 1'b1, 1'b0},   // 0 -> 59
            {tod_pkg::REQ_UP,   1'b1, 1'b1},   // 59 -> 0
            {tod_pkg::REQ_DOWN, 1'b1, 1'b0},   // back to 59
            {tod_pkg::REQ_NEXT, 1'b1, 1'b0},   // seconds
            {tod_pkg::REQ_DOWN, 1'b1, 1'b0},   // 1 -> 0
            {tod_pkg::REQ_DOWN, 1'b1, 1'b0},   // 0 -> 59
            {tod_pkg::REQ_UP,   1'b1, 1'b0},   // 59 -> 0
            {tod_pkg::REQ_DOWN, 1'b1, 1'b0},   // back to 59
            {tod_pkg::REQ_TICK, 1'b1, 1'b0},   // 23:59:59 rolls to 00:00:00 while setting
            {tod_pkg::REQ_NEXT, 1'b1, 1'b1},   // backward seconds to minutes
            {tod_pkg::REQ_DOWN, 1'b0, 1'b1}
        };
        foreach (directed_reqs[k])
            send_request(directed_reqs[k]);

        // Random mix, heavy on ticks and set keys
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            tail_phase = (i >= RANDOM_ITEMS - TAIL_ITEMS);

            // Hold off the receiver while the sender keeps pushing
            if (i == 300) begin
                sink_hold_request = 1'b1;
                burst_until = i + 40;
            end

            // Pause the sender until the pipeline has drained
            if (i == 600) begin
                @(negedge aclk);
                s_valid = 1'b0;
                while (board.pending() != 0) @(negedge aclk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 40)      next_req.req_type = tod_pkg::REQ_TICK;
            else if (pick < 55) next_req.req_type = tod_pkg::REQ_UP;
            else if (pick < 70) next_req.req_type = tod_pkg::REQ_DOWN;
            else if (pick < 85) next_req.req_type = tod_pkg::REQ_NEXT;
            else if (pick < 93) next_req.req_type = REQ_OTHER;
            else next_req.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            next_req.key_pressed = ($urandom_range(0, 7) != 0);
            next_req.shift_held  = 1'($urandom_range(0, 1));
            send_request(next_req);

            if (!tail_phase && i >= burst_until && (i / 100) % 3 != 0
                && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 15));
        end

        // Drain and let the pipeline settle
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (m_valid)
            board.report_mismatch("result still valid after all expected results arrived");

        $display("Sent %0d requests, checked %0d results, %0d long receiver hold-offs",
                 sent_count, board.checked, holds_done);
        $display("Covered %0d ticks (%0d minute and %0d hour carries), %0d set-key presses, %0d %s",
                 board.ticks, board.minute_carries, board.hour_carries,
                 board.set_presses, board.passed_keys, "passed-on keys");
        if (board.mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tod_pkg.sv
hw/rtl/tod_in_stage.sv
hw/rtl/tod_core.sv
hw/rtl/settable_time_of_day_clock_unit.sv
hw/rtl/tod_checker.sv
sim/tb_top.sv
